// File: rtl/flash_save_sector_table_top_macros.svh
// ----------------------------------------------------------------------------
// Flash save sector table assertion macros
// Shared concurrent assertion forms for the sector table.
// ----------------------------------------------------------------------------
`ifndef FLASH_SAVE_SECTOR_TABLE_TOP_MACROS_SVH
`define FLASH_SAVE_SECTOR_TABLE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FSST_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FSST_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/fsst_pkg.sv
// ----------------------------------------------------------------------------
// Flash save sector table package
// Request and result types, opcodes, sequencer states and constants.
// ----------------------------------------------------------------------------
package fsst_pkg;

  localparam int SECTOR_COUNT_DEF = 16;
  localparam int SECTOR_W         = 5;
  localparam int SLOT_W           = 5;
  localparam int COUNTER_W        = 16;
  localparam int RND_W            = 32;
  localparam int BIT_W            = $clog2(RND_W);

  localparam logic [SECTOR_W-1:0]  NO_SECTOR   = 5'd16;
  localparam logic [SLOT_W-1:0]    NO_SLOT     = 5'd16;
  localparam logic [7:0]           SLOT_MAX    = 8'd15;
  localparam logic [COUNTER_W-1:0] LIMIT_RESET = 16'hFDE8;

  localparam logic [2:0] OP_CLEAR   = 3'd0;
  localparam logic [2:0] OP_SCAN    = 3'd1;
  localparam logic [2:0] OP_LOOKUP  = 3'd2;
  localparam logic [2:0] OP_CHOOSE  = 3'd3;
  localparam logic [2:0] OP_RECORD  = 3'd4;
  localparam logic [2:0] OP_RELEASE = 3'd5;

  typedef struct packed {
    logic [2:0]           opcode;
    logic [7:0]           save_slot;
    logic [3:0]           sector_index;
    logic                 magic_ok;
    logic                 checksum_ok;
    logic [COUNTER_W-1:0] header_counter;
    logic [RND_W-1:0]     random_value;
  } req_t;

  typedef struct packed {
    logic [SECTOR_W-1:0]  result_sector;
    logic [COUNTER_W-1:0] result_counter;
    logic                 failed;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SCAN,
    ST_WALK,
    ST_DECIDE,
    ST_DIV,
    ST_PICK,
    ST_REC_DROP,
    ST_REC_WRITE,
    ST_DONE
  } state_e;

endpackage

// File: rtl/flash_save_sector_table_top.sv
// ----------------------------------------------------------------------------
// Flash save sector table
// Sector table with mount scan, newest lookup, free choice, save and release.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The block then runs
// a small sequencer that walks the table one entry per cycle through a single
// compare unit, and busy stays high until the result is shown. The result is
// on rsp_o with done_o high for exactly one cycle and stays on rsp_o until
// the next request is taken; the receiver cannot stall it, so the block
// never waits on the output side. A clear walks every entry, a scan walks up
// to its index, and release and bad requests go straight to the result.
// Lookup, choose and record walk the whole table and then decide; a record
// with a usable free sector then runs a drop step and a write step.
// With two or more free sectors a 32-step restoring remainder unit (one bit
// per cycle) picks among them, followed by a second walk that stops at the
// chosen entry.
// The counter_limit register is written over cfg_data_i whenever cfg_valid_i
// is high; cfg_ready_o is always high. Reset empties every table entry and
// loads counter_limit with 65000.
module flash_save_sector_table_top #(
  parameter int SECTOR_COUNT = fsst_pkg::SECTOR_COUNT_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  fsst_pkg::req_t                   req_i,
  output logic                             done_o,
  output fsst_pkg::rsp_t                   rsp_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [fsst_pkg::COUNTER_W-1:0]   cfg_data_i
);

  localparam int IDX_W = $clog2(SECTOR_COUNT);
  localparam int CNT_W = $clog2(SECTOR_COUNT + 1);
  localparam int SEC_W = fsst_pkg::SECTOR_W;
  localparam int CTR_W = fsst_pkg::COUNTER_W;
  localparam int RND_W = fsst_pkg::RND_W;
  localparam int BIT_W = fsst_pkg::BIT_W;
  localparam int SLW   = fsst_pkg::SLOT_W;

  fsst_pkg::state_e state_q, state_d;

  logic                valid_q [SECTOR_COUNT];
  logic [SLW-1:0]      slot_q  [SECTOR_COUNT];
  logic [CTR_W-1:0]    cnt_q   [SECTOR_COUNT];

  fsst_pkg::req_t      req_q, req_d;
  fsst_pkg::rsp_t      res_q, res_d;
  logic [CTR_W-1:0]    limit_q;
  logic [IDX_W-1:0]    ptr_q, ptr_d;
  logic [CTR_W-1:0]    best_q, best_d;
  logic [IDX_W-1:0]    old_q, old_d;
  logic                old_found_q, old_found_d;
  logic [CNT_W-1:0]    free_cnt_q, free_cnt_d;
  logic [IDX_W-1:0]    first_free_q, first_free_d;
  logic [IDX_W-1:0]    fresh_q, fresh_d;
  logic [CNT_W-1:0]    rem_q, rem_d;
  logic [RND_W-1:0]    rnd_q, rnd_d;
  logic [BIT_W-1:0]    bit_q, bit_d;
  logic [CNT_W-1:0]    seen_q, seen_d;
  logic                own_lost_q, own_lost_d;

  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  logic                wr_valid;
  logic [SLW-1:0]      wr_slot;
  logic [CTR_W-1:0]    wr_cnt;

  logic                rd_valid;
  logic [SLW-1:0]      rd_slot;
  logic [CTR_W-1:0]    rd_cnt;

  logic                accept;
  logic                in_idx_ok;
  logic [IDX_W-1:0]    idx_int;
  logic                slot_match;
  logic                scan_active;
  logic                scan_keep;
  logic [CTR_W-1:0]    scan_cnt;
  logic                last_ptr;
  logic [CTR_W:0]      cnt_next;
  logic                wrap;
  logic                swap_old;
  logic [IDX_W-1:0]    rec_addr;
  logic [CTR_W-1:0]    rec_cnt;
  logic [CNT_W:0]      div_t;
  logic [CNT_W:0]      div_n;
  logic [CNT_W:0]      div_r;

  assign busy        = (state_q != fsst_pkg::ST_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;
  assign rsp_o       = res_q;

  assign rd_valid = valid_q[ptr_q];
  assign rd_slot  = slot_q[ptr_q];
  assign rd_cnt   = cnt_q[ptr_q];

  assign in_idx_ok   = int'(req_i.sector_index) < SECTOR_COUNT;
  assign idx_int     = IDX_W'(req_q.sector_index);
  assign slot_match  = (8'(rd_slot) == req_q.save_slot);
  assign scan_active = req_q.magic_ok && req_q.checksum_ok &&
                       (req_q.save_slot <= fsst_pkg::SLOT_MAX);
  assign scan_keep   = scan_active && !own_lost_q;
  assign scan_cnt    = req_q.magic_ok ? req_q.header_counter : '0;
  assign last_ptr    = (ptr_q == IDX_W'(SECTOR_COUNT - 1));
  assign cnt_next    = {1'b0, best_q} + (CTR_W + 1)'(1);
  assign wrap        = cnt_next > {1'b0, limit_q};
  assign swap_old    = wrap && old_found_q;
  assign rec_addr    = swap_old ? old_q : fresh_q;
  assign rec_cnt     = wrap ? CTR_W'(1) : cnt_next[CTR_W-1:0];

  assign div_t = {rem_q, rnd_q[RND_W-1]};
  assign div_n = {1'b0, free_cnt_q};
  assign div_r = (div_t >= div_n) ? (div_t - div_n) : div_t;

  always_comb begin
    state_d = state_q;
    case (state_q)
      fsst_pkg::ST_IDLE: begin
        if (accept) begin
          case (req_i.opcode)
            fsst_pkg::OP_CLEAR:   state_d = fsst_pkg::ST_CLEAR;
            fsst_pkg::OP_SCAN:    state_d = in_idx_ok ? fsst_pkg::ST_SCAN : fsst_pkg::ST_DONE;
            fsst_pkg::OP_LOOKUP:  state_d = fsst_pkg::ST_WALK;
            fsst_pkg::OP_CHOOSE:  state_d = fsst_pkg::ST_WALK;
            fsst_pkg::OP_RECORD: begin
              state_d = (req_i.save_slot <= fsst_pkg::SLOT_MAX) ? fsst_pkg::ST_WALK
                                                                 : fsst_pkg::ST_DONE;
            end
            default:              state_d = fsst_pkg::ST_DONE;
          endcase
        end
      end
      fsst_pkg::ST_CLEAR: begin
        if (last_ptr) begin
          state_d = fsst_pkg::ST_DONE;
        end
      end
      fsst_pkg::ST_SCAN: begin
        if (ptr_q == idx_int) begin
          state_d = fsst_pkg::ST_DONE;
        end
      end
      fsst_pkg::ST_WALK: begin
        if (last_ptr) begin
          state_d = fsst_pkg::ST_DECIDE;
        end
      end
      fsst_pkg::ST_DECIDE: begin
        if (req_q.opcode == fsst_pkg::OP_LOOKUP) begin
          state_d = fsst_pkg::ST_DONE;
        end else if (free_cnt_q == CNT_W'(0) ||
                     (free_cnt_q == CNT_W'(1) && !old_found_q)) begin
          state_d = fsst_pkg::ST_DONE;
        end else if (free_cnt_q == CNT_W'(1)) begin
          state_d = (req_q.opcode == fsst_pkg::OP_RECORD) ? fsst_pkg::ST_REC_DROP
                                                          : fsst_pkg::ST_DONE;
        end else begin
          state_d = fsst_pkg::ST_DIV;
        end
      end
      fsst_pkg::ST_DIV: begin
        if (bit_q == BIT_W'(RND_W - 1)) begin
          state_d = fsst_pkg::ST_PICK;
        end
      end
      fsst_pkg::ST_PICK: begin
        if (!rd_valid && seen_q == rem_q) begin
          state_d = (req_q.opcode == fsst_pkg::OP_RECORD) ? fsst_pkg::ST_REC_DROP
                                                          : fsst_pkg::ST_DONE;
        end
      end
      fsst_pkg::ST_REC_DROP:  state_d = fsst_pkg::ST_REC_WRITE;
      fsst_pkg::ST_REC_WRITE: state_d = fsst_pkg::ST_DONE;
      fsst_pkg::ST_DONE:      state_d = fsst_pkg::ST_IDLE;
      default:                state_d = fsst_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req_d        = req_q;
    res_d        = res_q;
    ptr_d        = ptr_q;
    best_d       = best_q;
    old_d        = old_q;
    old_found_d  = old_found_q;
    free_cnt_d   = free_cnt_q;
    first_free_d = first_free_q;
    fresh_d      = fresh_q;
    rem_d        = rem_q;
    rnd_d        = rnd_q;
    bit_d        = bit_q;
    seen_d       = seen_q;
    own_lost_d   = own_lost_q;
    wr_en        = 1'b0;
    wr_addr      = ptr_q;
    wr_valid     = 1'b0;
    wr_slot      = fsst_pkg::NO_SLOT;
    wr_cnt       = '0;
    done_o       = 1'b0;
    case (state_q)
      fsst_pkg::ST_IDLE: begin
        if (accept) begin
          req_d       = req_i;
          res_d       = '{result_sector: fsst_pkg::NO_SECTOR, result_counter: '0,
                          failed: 1'b1};
          ptr_d       = '0;
          best_d      = '0;
          old_found_d = 1'b0;
          free_cnt_d  = '0;
          own_lost_d  = 1'b0;
          if (req_i.opcode == fsst_pkg::OP_RELEASE && in_idx_ok) begin
            wr_en   = 1'b1;
            wr_addr = IDX_W'(req_i.sector_index);
            res_d   = '{result_sector: SEC_W'(req_i.sector_index), result_counter: '0,
                        failed: 1'b0};
          end
        end
      end
      fsst_pkg::ST_CLEAR: begin
        wr_en = 1'b1;
        ptr_d = ptr_q + IDX_W'(1);
        if (last_ptr) begin
          res_d = '{result_sector: fsst_pkg::NO_SECTOR, result_counter: '0,
                    failed: 1'b0};
        end
      end
      fsst_pkg::ST_SCAN: begin
        if (ptr_q == idx_int) begin
          wr_en    = 1'b1;
          wr_valid = scan_keep;
          wr_slot  = scan_active ? SLW'(req_q.save_slot) : fsst_pkg::NO_SLOT;
          wr_cnt   = scan_cnt;
          res_d    = '{result_sector: SEC_W'(idx_int), result_counter: scan_cnt,
                       failed: !scan_keep};
        end else begin
          if (scan_active && slot_match) begin
            if (rd_cnt < req_q.header_counter) begin
              wr_en   = 1'b1;
              wr_slot = rd_slot;
              wr_cnt  = rd_cnt;
            end else begin
              own_lost_d = 1'b1;
            end
          end
          ptr_d = ptr_q + IDX_W'(1);
        end
      end
      fsst_pkg::ST_WALK: begin
        if (!rd_valid) begin
          free_cnt_d = free_cnt_q + CNT_W'(1);
          if (free_cnt_q == CNT_W'(0)) begin
            first_free_d = ptr_q;
          end
        end else if (slot_match && best_q < rd_cnt) begin
          best_d      = rd_cnt;
          old_d       = ptr_q;
          old_found_d = 1'b1;
        end
        ptr_d = ptr_q + IDX_W'(1);
      end
      fsst_pkg::ST_DECIDE: begin
        if (req_q.opcode == fsst_pkg::OP_LOOKUP) begin
          res_d = '{result_sector: old_found_q ? SEC_W'(old_q) : fsst_pkg::NO_SECTOR,
                    result_counter: best_q, failed: !old_found_q};
        end else if (free_cnt_q == CNT_W'(1) && old_found_q) begin
          fresh_d = first_free_q;
          res_d   = '{result_sector: SEC_W'(first_free_q), result_counter: '0,
                      failed: 1'b0};
        end else begin
          rnd_d = req_q.random_value;
          rem_d = '0;
          bit_d = '0;
        end
      end
      fsst_pkg::ST_DIV: begin
        rem_d  = div_r[CNT_W-1:0];
        rnd_d  = {rnd_q[RND_W-2:0], 1'b0};
        bit_d  = bit_q + BIT_W'(1);
        ptr_d  = '0;
        seen_d = '0;
      end
      fsst_pkg::ST_PICK: begin
        if (!rd_valid) begin
          if (seen_q == rem_q) begin
            fresh_d = ptr_q;
            res_d   = '{result_sector: SEC_W'(ptr_q), result_counter: '0, failed: 1'b0};
          end
          seen_d = seen_q + CNT_W'(1);
        end
        ptr_d = ptr_q + IDX_W'(1);
      end
      fsst_pkg::ST_REC_DROP: begin
        wr_en   = old_found_q;
        wr_addr = wrap ? fresh_q : old_q;
      end
      fsst_pkg::ST_REC_WRITE: begin
        wr_en    = 1'b1;
        wr_addr  = rec_addr;
        wr_valid = 1'b1;
        wr_slot  = SLW'(req_q.save_slot);
        wr_cnt   = rec_cnt;
        res_d    = '{result_sector: SEC_W'(rec_addr), result_counter: rec_cnt,
                     failed: 1'b0};
      end
      fsst_pkg::ST_DONE: begin
        done_o = 1'b1;
      end
      default: begin
        done_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fsst_pkg::ST_IDLE;
      limit_q     <= fsst_pkg::LIMIT_RESET;
      ptr_q       <= '0;
      old_found_q <= 1'b0;
      free_cnt_q  <= '0;
      seen_q      <= '0;
      bit_q       <= '0;
      own_lost_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      old_found_q <= old_found_d;
      free_cnt_q  <= free_cnt_d;
      seen_q      <= seen_d;
      bit_q       <= bit_d;
      own_lost_q  <= own_lost_d;
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    res_q        <= res_d;
    best_q       <= best_d;
    old_q        <= old_d;
    first_free_q <= first_free_d;
    fresh_q      <= fresh_d;
    rem_q        <= rem_d;
    rnd_q        <= rnd_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SECTOR_COUNT; i++) begin
        valid_q[i] <= 1'b0;
        slot_q[i]  <= fsst_pkg::NO_SLOT;
        cnt_q[i]   <= '0;
      end
    end else if (wr_en) begin
      valid_q[wr_addr] <= wr_valid;
      slot_q[wr_addr]  <= wr_slot;
      cnt_q[wr_addr]   <= wr_cnt;
    end
  end

`include "flash_save_sector_table_top_macros.svh"

  `FSST_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, accept, busy, "Accepted request did not raise busy.")
  `FSST_ASSERT_IMP(a_done_busy, clk_i, rst_ni, done_o, busy, "Result strobe while not busy.")
  `FSST_ASSERT_NXT(a_done_once, clk_i, rst_ni, done_o, !busy && !done_o, "Result not single.")

endmodule

// File: dv/fsst_checker.sv
// ----------------------------------------------------------------------------
// Flash save sector table checker
// Watches the request, result and limit channels of the sector table, keeps
// its own copy of the table to predict each result, and compares every
// result field by field against the oldest prediction in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fsst_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic                           busy_i,
  input  fsst_pkg::req_t                 req_i,
  input  logic                           done_i,
  input  fsst_pkg::rsp_t                 rsp_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [fsst_pkg::COUNTER_W-1:0] cfg_data_i,
  output int                             fail_count_o,
  output int                             pending_o
);

  localparam int SECTORS = fsst_pkg::SECTOR_COUNT_DEF;
  localparam int CTR_W   = fsst_pkg::COUNTER_W;
  localparam int SLW     = fsst_pkg::SLOT_W;

  logic             sec_valid [SECTORS];
  logic [SLW-1:0]   sec_slot  [SECTORS];
  logic [CTR_W-1:0] sec_count [SECTORS];
  logic [CTR_W-1:0] limit_q;
  fsst_pkg::rsp_t   predicted_q [$];

  function automatic void drop_sector(input int i);
    sec_valid[i] = 1'b0;
    sec_slot[i]  = fsst_pkg::NO_SLOT;
    sec_count[i] = '0;
  endfunction

  // Returns the newest sector of a slot and its counter; zero counters never win.
  function automatic int newest_sector(input logic [7:0] s,
                                       output logic [CTR_W-1:0] best);
    int found;
    found = SECTORS;
    best  = '0;
    for (int i = 0; i < SECTORS; i++) begin
      if (sec_valid[i] && {3'b000, sec_slot[i]} == s && best < sec_count[i]) begin
        best  = sec_count[i];
        found = i;
      end
    end
    return found;
  endfunction

  function automatic int pick_free(input logic [7:0] s,
                                   input logic [fsst_pkg::RND_W-1:0] rnd);
    int               free_list [SECTORS];
    int               n;
    logic [CTR_W-1:0] top_count;
    n = 0;
    for (int i = 0; i < SECTORS; i++) begin
      if (!sec_valid[i]) begin
        free_list[n] = i;
        n++;
      end
    end
    if (n == 0) return SECTORS;
    if (n == 1) return (newest_sector(s, top_count) == SECTORS) ? SECTORS : free_list[0];
    return free_list[int'(rnd % n)];
  endfunction

  function automatic fsst_pkg::rsp_t apply_request(input fsst_pkg::req_t r);
    fsst_pkg::rsp_t   res;
    int               idx;
    int               old_sec;
    int               new_sec;
    logic [CTR_W-1:0] top_count;
    logic [CTR_W:0]   next_count;
    res.result_sector  = fsst_pkg::NO_SECTOR;
    res.result_counter = '0;
    res.failed         = 1'b1;
    idx = int'(r.sector_index);
    case (r.opcode)
      fsst_pkg::OP_CLEAR: begin
        for (int i = 0; i < SECTORS; i++) drop_sector(i);
        res.failed = 1'b0;
      end
      fsst_pkg::OP_SCAN: begin
        drop_sector(idx);
        if (r.magic_ok) begin
          sec_count[idx] = r.header_counter;
          if (r.save_slot <= fsst_pkg::SLOT_MAX && r.checksum_ok) begin
            sec_valid[idx] = 1'b1;
            sec_slot[idx]  = r.save_slot[SLW-1:0];
            for (int j = 0; j < idx; j++) begin
              if ({3'b000, sec_slot[j]} == r.save_slot) begin
                if (sec_count[j] < r.header_counter) sec_valid[j] = 1'b0;
                else sec_valid[idx] = 1'b0;
              end
            end
          end
        end
        res.result_sector  = fsst_pkg::SECTOR_W'(idx);
        res.result_counter = sec_count[idx];
        res.failed         = !sec_valid[idx];
      end
      fsst_pkg::OP_LOOKUP: begin
        old_sec = newest_sector(r.save_slot, top_count);
        res.result_sector  = fsst_pkg::SECTOR_W'(old_sec);
        res.result_counter = top_count;
        res.failed         = (old_sec == SECTORS);
      end
      fsst_pkg::OP_CHOOSE: begin
        new_sec = pick_free(r.save_slot, r.random_value);
        res.result_sector = fsst_pkg::SECTOR_W'(new_sec);
        res.failed        = (new_sec == SECTORS);
      end
      fsst_pkg::OP_RECORD: begin
        if (r.save_slot <= fsst_pkg::SLOT_MAX) begin
          old_sec = newest_sector(r.save_slot, top_count);
          new_sec = pick_free(r.save_slot, r.random_value);
          if (new_sec < SECTORS) begin
            next_count = {1'b0, top_count} + 1'b1;
            if (old_sec < SECTORS) drop_sector(old_sec);
            if (next_count > {1'b0, limit_q}) begin
              next_count = (CTR_W + 1)'(1);
              if (old_sec < SECTORS) begin
                drop_sector(new_sec);
                new_sec = old_sec;
              end
            end
            sec_valid[new_sec] = 1'b1;
            sec_slot[new_sec]  = r.save_slot[SLW-1:0];
            sec_count[new_sec] = next_count[CTR_W-1:0];
            res.result_sector  = fsst_pkg::SECTOR_W'(new_sec);
            res.result_counter = next_count[CTR_W-1:0];
            res.failed         = 1'b0;
          end
        end
      end
      fsst_pkg::OP_RELEASE: begin
        drop_sector(idx);
        res.result_sector = fsst_pkg::SECTOR_W'(idx);
        res.failed        = 1'b0;
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      fail_count_o++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    fsst_pkg::rsp_t want;
    if (!rst_ni) begin
      for (int i = 0; i < SECTORS; i++) drop_sector(i);
      limit_q = fsst_pkg::LIMIT_RESET;
      predicted_q.delete();
      fail_count_o = 0;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) limit_q = cfg_data_i;
      if (done_i) begin
        if (predicted_q.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected result: expected none, %s %0d counter %0d failed %0b",
                   $time, "actual sector", rsp_i.result_sector, rsp_i.result_counter,
                   rsp_i.failed);
        end else begin
          want = predicted_q.pop_front();
          check_field("result_sector", want.result_sector, rsp_i.result_sector);
          check_field("result_counter", want.result_counter, rsp_i.result_counter);
          check_field("failed", want.failed, rsp_i.failed);
        end
      end
      if (start_i && !busy_i) predicted_q.push_back(apply_request(req_i));
      pending_o <= predicted_q.size();
    end
  end

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// Flash save sector table testbench
// Drives directed and random requests through the sector table: mount scans,
// lookups, free choices, saves and releases, over several counter limits.
// A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int              SECTORS        = fsst_pkg::SECTOR_COUNT_DEF;
  localparam int              CTR_W          = fsst_pkg::COUNTER_W;
  localparam int              PHASE_ITEMS    = 180;
  localparam int              WATCHDOG_LIMIT = 2000;
  localparam logic [2:0]      OP_SPARE       = 3'd6;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  fsst_pkg::req_t       req;
  logic                 done;
  fsst_pkg::rsp_t       rsp;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CTR_W-1:0]     cfg_data;
  int                   fail_count;
  int                   pending;
  int                   sent_count = 0;
  int                   idle_cycles = 0;
  logic [CTR_W-1:0]     cur_limit = fsst_pkg::LIMIT_RESET;
  logic                 no_idle = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  flash_save_sector_table_top u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start       (start),
    .busy        (busy),
    .req_i       (req),
    .done_o      (done),
    .rsp_o       (rsp),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  fsst_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start_i      (start),
    .busy_i       (busy),
    .req_i        (req),
    .done_i       (done),
    .rsp_i        (rsp),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk) begin
    if ((start && !busy) || done || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  function automatic int idle_gap();
    int p;
    if (no_idle) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  function automatic fsst_pkg::req_t make_req(input logic [2:0] op, input logic [7:0] s,
                                              input logic [3:0] sec, input logic magic,
                                              input logic csum,
                                              input logic [CTR_W-1:0] hcnt,
                                              input logic [fsst_pkg::RND_W-1:0] rnd);
    fsst_pkg::req_t r;
    r.opcode         = op;
    r.save_slot      = s;
    r.sector_index   = sec;
    r.magic_ok       = magic;
    r.checksum_ok    = csum;
    r.header_counter = hcnt;
    r.random_value   = rnd;
    return r;
  endfunction

  function automatic fsst_pkg::req_t noise_req();
    return make_req(3'($urandom_range(0, 7)), 8'($urandom), 4'($urandom), 1'($urandom),
                    1'($urandom), 16'($urandom), $urandom);
  endfunction

  // Few slots most of the time, so that sectors of one slot collide.
  function automatic logic [7:0] slot_pick();
    int p;
    p = $urandom_range(0, 99);
    if (p < 70) return 8'($urandom_range(0, 3));
    if (p < 95) return 8'($urandom_range(0, 15));
    return 8'($urandom_range(16, 255));
  endfunction

  function automatic logic [CTR_W-1:0] header_count();
    case ($urandom_range(0, 4))
      0: return 16'($urandom_range(0, 20));
      1: return cur_limit + 16'($urandom_range(0, 4)) - 16'd2;
      2: return 16'($urandom);
      3: return 16'hFFFF;
      default: return 16'd0;
    endcase
  endfunction

  task automatic issue(input fsst_pkg::req_t r);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
    sent_count++;
  endtask

  task automatic settle();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [CTR_W-1:0] v);
    repeat (idle_gap()) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_limit = v;
  endtask

  task automatic run_directed();
    issue(make_req(fsst_pkg::OP_LOOKUP, 8'd0, 4'd0, 1'b0, 1'b0, 16'd0, 32'd0));
    issue(make_req(fsst_pkg::OP_CHOOSE, 8'd0, 4'd0, 1'b0, 1'b0, 16'd0, 32'hFFFF_FFFF));
    issue(make_req(fsst_pkg::OP_RECORD, 8'd255, 4'd0, 1'b0, 1'b0, 16'd0, 32'd7));
    issue(make_req(fsst_pkg::OP_RECORD, 8'd0, 4'd0, 1'b0, 1'b0, 16'd0, 32'd0));
    issue(make_req(fsst_pkg::OP_SCAN, 8'd1, 4'd5, 1'b0, 1'b1, 16'd9, 32'd0));
    issue(make_req(fsst_pkg::OP_SCAN, 8'd1, 4'd6, 1'b1, 1'b0, 16'h1234, 32'd0));
    issue(make_req(fsst_pkg::OP_SCAN, 8'd0, 4'd3, 1'b1, 1'b1, 16'hFFFF, 32'd0));
    // The slot's counter is at its top, so the save wraps into its old sector.
    issue(make_req(fsst_pkg::OP_RECORD, 8'd0, 4'd0, 1'b0, 1'b0, 16'd0, 32'd5));
    issue(make_req(fsst_pkg::OP_RELEASE, 8'd0, 4'd3, 1'b0, 1'b0, 16'd0, 32'd0));
    issue(make_req(OP_SPARE, 8'd0, 4'd0, 1'b0, 1'b0, 16'd0, 32'd0));
    issue(make_req(fsst_pkg::OP_CLEAR, 8'd0, 4'd0, 1'b0, 1'b0, 16'd0, 32'd0));
    for (int i = 0; i < SECTORS - 1; i++) begin
      issue(make_req(fsst_pkg::OP_SCAN, 8'(i), 4'(i), 1'b1, 1'b1, 16'(i), 32'd0));
    end
    // One sector left free: refused for a slot without a newest sector.
    issue(make_req(fsst_pkg::OP_CHOOSE, 8'd15, 4'd0, 1'b0, 1'b0, 16'd0, 32'd3));
    issue(make_req(fsst_pkg::OP_RECORD, 8'd2, 4'd0, 1'b0, 1'b0, 16'd0, 32'd3));
  endtask

  task automatic run_sequence();
    int             kind;
    logic           distinct;
    fsst_pkg::req_t r;
    no_idle = ($urandom_range(0, 4) == 0);
    kind    = $urandom_range(0, 99);
    if (kind < 10) begin
      distinct = ($urandom_range(0, 2) == 0);
      r = noise_req();
      r.opcode = fsst_pkg::OP_CLEAR;
      issue(r);
      for (int i = 0; i < SECTORS; i++) begin
        r = noise_req();
        r.opcode         = fsst_pkg::OP_SCAN;
        r.sector_index   = 4'(i);
        r.magic_ok       = ($urandom_range(0, 9) != 0);
        r.checksum_ok    = ($urandom_range(0, 9) != 0);
        r.save_slot      = distinct ? 8'(i) : slot_pick();
        r.header_counter = header_count();
        issue(r);
      end
    end else if (kind < 80) begin
      repeat ($urandom_range(1, 8)) begin
        r = noise_req();
        r.save_slot = slot_pick();
        case ($urandom_range(0, 9))
          0, 1, 2, 3: r.opcode = fsst_pkg::OP_RECORD;
          4, 5:       r.opcode = fsst_pkg::OP_LOOKUP;
          6:          r.opcode = fsst_pkg::OP_CHOOSE;
          7, 8:       r.opcode = fsst_pkg::OP_RELEASE;
          default: begin
            r.opcode         = fsst_pkg::OP_SCAN;
            r.magic_ok       = 1'b1;
            r.checksum_ok    = 1'b1;
            r.header_counter = header_count();
          end
        endcase
        issue(r);
      end
    end else begin
      repeat ($urandom_range(1, 4)) issue(noise_req());
    end
  endtask

  initial begin
    logic [CTR_W-1:0] limits [6];
    int               target;
    limits = '{fsst_pkg::LIMIT_RESET, 16'd0, 16'd3, 16'hFFFF, 16'd1,
               16'($urandom_range(2, 30))};
    rst_n     <= 1'b0;
    start     <= 1'b0;
    req       <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    foreach (limits[p]) begin
      start <= 1'b0;
      settle();
      write_limit(limits[p]);
      target = sent_count + PHASE_ITEMS;
      while (sent_count < target) run_sequence();
    end
    start <= 1'b0;
    settle();
    repeat (80) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
